@@ design/abct_pkg.sv @@
package abct_pkg;

  // default field widths
  localparam int COORD_BITS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 12;
  localparam int MOVE_BITS      = 12;
  localparam int ANCHOR_BITS    = 4;
  localparam int KIND_BITS      = 3;

  // operation codes
  localparam logic [KIND_BITS-1:0] KIND_LOAD    = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_OVERLAP = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_POINT   = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_LEFT    = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_RIGHT   = 3'd4;
  localparam logic [KIND_BITS-1:0] KIND_TOP     = 3'd5;
  localparam logic [KIND_BITS-1:0] KIND_BOTTOM  = 3'd6;
  localparam logic [KIND_BITS-1:0] KIND_NONE    = 3'd7;

  // anchor codes
  localparam logic [ANCHOR_BITS-1:0] ANC_CENTER        = 4'd0;
  localparam logic [ANCHOR_BITS-1:0] ANC_CENTER_TOP    = 4'd1;
  localparam logic [ANCHOR_BITS-1:0] ANC_CENTER_LEFT   = 4'd2;
  localparam logic [ANCHOR_BITS-1:0] ANC_CENTER_RIGHT  = 4'd3;
  localparam logic [ANCHOR_BITS-1:0] ANC_CENTER_BOTTOM = 4'd4;
  localparam logic [ANCHOR_BITS-1:0] ANC_TOP_LEFT      = 4'd5;
  localparam logic [ANCHOR_BITS-1:0] ANC_TOP_RIGHT     = 4'd6;
  localparam logic [ANCHOR_BITS-1:0] ANC_BOTTOM_LEFT   = 4'd7;
  localparam logic [ANCHOR_BITS-1:0] ANC_BOTTOM_RIGHT  = 4'd8;

  // how far the anchor sits from the top-left corner along one axis
  typedef enum logic [1:0] {
    OFF_NONE = 2'd0,
    OFF_HALF = 2'd1,
    OFF_FULL = 2'd2
  } off_e;

  typedef struct packed {
    off_e x;
    off_e y;
  } anchor_off_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic edge_en;
    logic cmp_en;
  } cmd_t;

  function automatic anchor_off_t anchor_offsets(logic [ANCHOR_BITS-1:0] a);
    anchor_off_t o;
    o.x = OFF_NONE;
    o.y = OFF_NONE;
    case (a)
      ANC_CENTER: begin
        o.x = OFF_HALF;
        o.y = OFF_HALF;
      end
      ANC_CENTER_TOP: begin
        o.x = OFF_HALF;
      end
      ANC_CENTER_LEFT: begin
        o.y = OFF_HALF;
      end
      ANC_CENTER_RIGHT: begin
        o.x = OFF_FULL;
        o.y = OFF_HALF;
      end
      ANC_CENTER_BOTTOM: begin
        o.x = OFF_HALF;
        o.y = OFF_FULL;
      end
      ANC_TOP_RIGHT: begin
        o.x = OFF_FULL;
      end
      ANC_BOTTOM_LEFT: begin
        o.y = OFF_FULL;
      end
      ANC_BOTTOM_RIGHT: begin
        o.x = OFF_FULL;
        o.y = OFF_FULL;
      end
      default: begin
        // top-left and unused codes
        o.x = OFF_NONE;
        o.y = OFF_NONE;
      end
    endcase
    return o;
  endfunction

endpackage

@@ design/abct_ctrl.sv @@
module abct_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic [abct_pkg::KIND_BITS-1:0]   kind_i,
  input  logic                             out_stall_i,
  output logic                             in_stall_o,
  output logic                             out_valid_o,
  output abct_pkg::cmd_t                   cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EDGE = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  logic   is_test;

  assign accept  = in_valid_i && (state_q == ST_IDLE);
  assign is_test = (kind_i != abct_pkg::KIND_LOAD) && (kind_i != abct_pkg::KIND_NONE);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);

  assign cmd_o.load    = accept && (kind_i == abct_pkg::KIND_LOAD);
  assign cmd_o.capture = accept && is_test;
  assign cmd_o.edge_en = (state_q == ST_EDGE);
  assign cmd_o.cmp_en  = (state_q == ST_CMP);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && is_test) state_d = ST_EDGE;
      end
      ST_EDGE: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_capture_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == ST_EDGE)
    else $error("test beat did not start the datapath");

  a_no_result_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_test |=> state_q == ST_IDLE)
    else $error("load or unused kind left idle");

  a_edge_then_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EDGE |=> state_q == ST_CMP)
    else $error("edge step not followed by compare");

  a_done_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_stall_i |=> state_q == ST_DONE)
    else $error("result dropped while stalled");

endmodule

@@ design/abct_dp.sv @@
module abct_dp #(
  parameter int COORD_BITS = abct_pkg::COORD_BITS_DEF,
  parameter int SIZE_BITS  = abct_pkg::SIZE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  abct_pkg::cmd_t                        cmd_i,
  input  logic [abct_pkg::KIND_BITS-1:0]        kind_i,
  input  logic signed [COORD_BITS-1:0]          pos_x_i,
  input  logic signed [COORD_BITS-1:0]          pos_y_i,
  input  logic [SIZE_BITS-1:0]                  width_i,
  input  logic [SIZE_BITS-1:0]                  height_i,
  input  logic [abct_pkg::ANCHOR_BITS-1:0]      anchor_i,
  input  logic signed [abct_pkg::MOVE_BITS-1:0] move_x_i,
  input  logic signed [abct_pkg::MOVE_BITS-1:0] move_y_i,
  output logic                                  hit_o
);

  localparam int CW   = COORD_BITS + 1;
  localparam int SW   = SIZE_BITS + 2;
  localparam int MW   = abct_pkg::MOVE_BITS + 1;
  localparam int PW   = (CW > SW) ? CW : SW;
  localparam int MAXW = (PW > MW) ? PW : MW;
  // headroom for corner plus size plus move
  localparam int W    = MAXW + 3;

  typedef logic signed [W-1:0] val_t;

  // one axis of a resolved box, half pixels
  typedef struct packed {
    val_t c;
    val_t s;
    val_t m;
    val_t sm;
  } axis_t;

  // interval ends, still and moved
  typedef struct packed {
    val_t lo;
    val_t hi;
    val_t lom;
    val_t him;
  } span_t;

  function automatic axis_t make_axis(val_t p, val_t sz, val_t mv, abct_pkg::off_e off);
    axis_t a;
    val_t  p2;
    p2     = p <<< 1;
    a.s    = sz <<< 1;
    a.m    = mv <<< 1;
    a.sm   = a.s + a.m;
    case (off)
      abct_pkg::OFF_HALF: a.c = p2 - sz;
      abct_pkg::OFF_FULL: a.c = p2 - a.s;
      default:            a.c = p2;
    endcase
    return a;
  endfunction

  function automatic span_t make_span(axis_t a);
    span_t s;
    s.lo  = a.c;
    s.hi  = a.c + a.s;
    s.lom = a.c + a.m;
    s.him = a.c + a.sm;
    return s;
  endfunction

  function automatic logic meets(val_t alo, val_t ahi, val_t blo, val_t bhi);
    return (alo < ahi) && (alo < bhi) && (blo < ahi) && (blo < bhi);
  endfunction

  // reference box
  logic signed [COORD_BITS-1:0]          ref_x_q, ref_y_q;
  logic [SIZE_BITS-1:0]                  ref_width_q, ref_height_q;
  logic [abct_pkg::ANCHOR_BITS-1:0]      ref_anchor_q;
  logic signed [abct_pkg::MOVE_BITS-1:0] ref_move_x_q, ref_move_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q      <= '0;
      ref_y_q      <= '0;
      ref_width_q  <= '0;
      ref_height_q <= '0;
      ref_anchor_q <= '0;
      ref_move_x_q <= '0;
      ref_move_y_q <= '0;
    end else if (cmd_i.load) begin
      ref_x_q      <= pos_x_i;
      ref_y_q      <= pos_y_i;
      ref_width_q  <= width_i;
      ref_height_q <= height_i;
      ref_anchor_q <= anchor_i;
      ref_move_x_q <= move_x_i;
      ref_move_y_q <= move_y_i;
    end
  end

  // corner resolution on the incoming beat
  abct_pkg::anchor_off_t r_off, b_off;
  axis_t rx_d, ry_d, bx_d, by_d;

  always_comb begin
    r_off = abct_pkg::anchor_offsets(ref_anchor_q);
    b_off = abct_pkg::anchor_offsets(anchor_i);
    rx_d  = make_axis(val_t'(ref_x_q), val_t'(ref_width_q), val_t'(ref_move_x_q), r_off.x);
    ry_d  = make_axis(val_t'(ref_y_q), val_t'(ref_height_q), val_t'(ref_move_y_q), r_off.y);
    bx_d  = make_axis(val_t'(pos_x_i), val_t'(width_i), val_t'(move_x_i), b_off.x);
    by_d  = make_axis(val_t'(pos_y_i), val_t'(height_i), val_t'(move_y_i), b_off.y);
  end

  logic [abct_pkg::KIND_BITS-1:0] kind_q;
  axis_t rx_q, ry_q, bx_q, by_q;
  val_t  qx_q, qy_q;
  span_t rxe_q, rye_q, bxe_q, bye_q;
  val_t  qx2_q, qy2_q;
  logic  hit_q, hit_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      rx_q   <= rx_d;
      ry_q   <= ry_d;
      bx_q   <= bx_d;
      by_q   <= by_d;
      qx_q   <= val_t'(pos_x_i) <<< 1;
      qy_q   <= val_t'(pos_y_i) <<< 1;
    end
    if (cmd_i.edge_en) begin
      rxe_q <= make_span(rx_q);
      rye_q <= make_span(ry_q);
      bxe_q <= make_span(bx_q);
      bye_q <= make_span(by_q);
      qx2_q <= qx_q + val_t'(2);
      qy2_q <= qy_q + val_t'(2);
    end
    if (cmd_i.cmp_en) begin
      hit_q <= hit_d;
    end
  end

  // point test keeps the still corner in qx_q and checks last pixel via qx2_q
  always_comb begin
    case (kind_q)
      abct_pkg::KIND_OVERLAP: begin
        hit_d = meets(rxe_q.lo, rxe_q.hi, bxe_q.lo, bxe_q.hi) &&
                meets(rye_q.lo, rye_q.hi, bye_q.lo, bye_q.hi);
      end
      abct_pkg::KIND_POINT: begin
        hit_d = (qx_q >= rxe_q.lo) && (qx2_q <= rxe_q.hi) &&
                (qy_q >= rye_q.lo) && (qy2_q <= rye_q.hi);
      end
      abct_pkg::KIND_LEFT: begin
        hit_d = (rxe_q.lo >= bxe_q.hi) && (rxe_q.lom < bxe_q.him) &&
                meets(rye_q.lom, rye_q.him, bye_q.lom, bye_q.him);
      end
      abct_pkg::KIND_RIGHT: begin
        hit_d = (rxe_q.hi <= bxe_q.lo) && (bxe_q.lom < rxe_q.him) &&
                meets(rye_q.lom, rye_q.him, bye_q.lom, bye_q.him);
      end
      abct_pkg::KIND_TOP: begin
        hit_d = (rye_q.lo >= bye_q.hi) && (rye_q.lom < bye_q.him) &&
                meets(rxe_q.lom, rxe_q.him, bxe_q.lom, bxe_q.him);
      end
      default: begin
        hit_d = (rye_q.hi <= bye_q.lo) && (bye_q.lom < rye_q.him) &&
                meets(rxe_q.lom, rxe_q.him, bxe_q.lom, bxe_q.him);
      end
    endcase
  end

  assign hit_o = hit_q;

endmodule

@@ design/anchored_box_collision_test.sv @@
// anchored box collision test
// holds one reference box and tests each later beat's box or point against it
// input channel: in_valid_i / in_stall_o carry kind, position, size, anchor
//   and pending move; a beat is taken when in_valid_i is high and in_stall_o low
// kind load stores the beat as the reference box and gives no result;
//   the unused kind is taken and dropped; every other kind gives one hit bit
// output channel: out_valid_o / out_stall_i carry hit_o
// result path: a test beat's corner resolve is registered at capture, the edge
//   sums in the edge step and the hit bit in the compare step, after which
//   out_valid_o rises in the done state
// a new test beat is taken only after the controller has walked the last one
//   through edge, compare and done and the result has left; while it is idle,
//   load and unused beats are taken every cycle
// the input is stalled from capture until the result beat has left
// while out_stall_i is high the result and out_valid_o hold unchanged
// reset: reference box clears to an empty box at the origin, anchor centre,
//   no move; the controller returns to idle with no result pending
module anchored_box_collision_test #(
  parameter int COORD_BITS = abct_pkg::COORD_BITS_DEF,
  parameter int SIZE_BITS  = abct_pkg::SIZE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [abct_pkg::KIND_BITS-1:0]        kind_i,
  input  logic signed [COORD_BITS-1:0]          pos_x_i,
  input  logic signed [COORD_BITS-1:0]          pos_y_i,
  input  logic [SIZE_BITS-1:0]                  width_i,
  input  logic [SIZE_BITS-1:0]                  height_i,
  input  logic [abct_pkg::ANCHOR_BITS-1:0]      anchor_i,
  input  logic signed [abct_pkg::MOVE_BITS-1:0] move_x_i,
  input  logic signed [abct_pkg::MOVE_BITS-1:0] move_y_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  hit_o
);

  // commands from the controller to the datapath
  abct_pkg::cmd_t cmd;

  // sequencer: idle, edge sums, compare, result held until taken
  abct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // reference box, corner resolve in half pixels, interval compares
  abct_dp #(
    .COORD_BITS (COORD_BITS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .kind_i   (kind_i),
    .pos_x_i  (pos_x_i),
    .pos_y_i  (pos_y_i),
    .width_i  (width_i),
    .height_i (height_i),
    .anchor_i (anchor_i),
    .move_x_i (move_x_i),
    .move_y_i (move_y_i),
    .hit_o    (hit_o)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int CW = abct_pkg::COORD_BITS_DEF;
  localparam int SW = abct_pkg::SIZE_BITS_DEF;
  localparam int MW = abct_pkg::MOVE_BITS;
  localparam int AW = abct_pkg::ANCHOR_BITS;
  localparam int KW = abct_pkg::KIND_BITS;

  // beats in the random part, loads included; unused-kind beats come on top of these
  localparam int RANDOM_BEATS = 1450;
  // once this few beats are left to send, neither side idles any more
  localparam int CALM_TAIL    = 150;
  // generous bound: every beat with a full sender gap, the controller's walk
  // and the longest receiver stall, taken several times over
  localparam int LIMIT_CYCLES = 250000;

  // one input beat as the block sees it
  typedef struct {
    logic [KW-1:0]        kind;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic [SW-1:0]        width;
    logic [SW-1:0]        height;
    logic [AW-1:0]        anchor;
    logic signed [MW-1:0] move_x;
    logic signed [MW-1:0] move_y;
  } box_beat_t;

  // a box with its top-left corner resolved, everything in half pixels
  typedef struct {
    longint x;
    longint y;
    longint w;
    longint h;
    longint mx;
    longint my;
  } half_box_t;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [KW-1:0]        kind_i     = '0;
  logic signed [CW-1:0] pos_x_i    = '0;
  logic signed [CW-1:0] pos_y_i    = '0;
  logic [SW-1:0]        width_i    = '0;
  logic [SW-1:0]        height_i   = '0;
  logic [AW-1:0]        anchor_i   = '0;
  logic signed [MW-1:0] move_x_i   = '0;
  logic signed [MW-1:0] move_y_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 hit_o;

  box_beat_t beats_to_send[$];
  logic      hits_awaited[$];

  // reference box as the block should hold it; reset gives an empty box
  // at the origin, anchor centre, no move
  box_beat_t held_ref = '{default: '0};

  // centre that the random beats cluster around, moved when a load hops somewhere new
  int aim_x = 0;
  int aim_y = 0;

  box_beat_t on_wire;
  int        send_gap      = 0;
  int        stall_left    = 0;
  bit        send_idles    = 1'b1;
  bit        recv_idles    = 1'b1;
  bit        calm          = 1'b0;
  logic      hit_wanted;
  int        fault_count   = 0;
  int        cycle_count   = 0;
  int        load_count    = 0;
  int        test_count    = 0;
  int        dropped_count = 0;
  int        hit_count     = 0;
  int        stall_cycles  = 0;
  int        gap_cycles    = 0;

  anchored_box_collision_test uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .width_i    (width_i),
    .height_i   (height_i),
    .anchor_i   (anchor_i),
    .move_x_i   (move_x_i),
    .move_y_i   (move_y_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .hit_o      (hit_o)
  );

  always #1 clk_i = ~clk_i;

  // resolve an anchored box to its top-left corner in half pixels;
  // half of a size in half pixels is the size in whole pixels, so odd
  // sizes stay exact
  function automatic half_box_t to_half_box(box_beat_t b);
    half_box_t hb;
    longint    ax;
    longint    ay;
    ax    = 2 * longint'(b.pos_x);
    ay    = 2 * longint'(b.pos_y);
    hb.w  = 2 * longint'(b.width);
    hb.h  = 2 * longint'(b.height);
    hb.mx = 2 * longint'(b.move_x);
    hb.my = 2 * longint'(b.move_y);
    hb.x  = ax;
    hb.y  = ay;
    case (b.anchor)
      abct_pkg::ANC_CENTER: begin
        hb.x = ax - longint'(b.width);
        hb.y = ay - longint'(b.height);
      end
      abct_pkg::ANC_CENTER_TOP: begin
        hb.x = ax - longint'(b.width);
      end
      abct_pkg::ANC_CENTER_LEFT: begin
        hb.y = ay - longint'(b.height);
      end
      abct_pkg::ANC_CENTER_RIGHT: begin
        hb.x = ax - hb.w;
        hb.y = ay - longint'(b.height);
      end
      abct_pkg::ANC_CENTER_BOTTOM: begin
        hb.x = ax - longint'(b.width);
        hb.y = ay - hb.h;
      end
      abct_pkg::ANC_TOP_RIGHT: begin
        hb.x = ax - hb.w;
      end
      abct_pkg::ANC_BOTTOM_LEFT: begin
        hb.y = ay - hb.h;
      end
      abct_pkg::ANC_BOTTOM_RIGHT: begin
        hb.x = ax - hb.w;
        hb.y = ay - hb.h;
      end
      default: begin
        // top-left, and the unused codes behave the same
      end
    endcase
    return hb;
  endfunction

  // two half-open spans share more than a single point
  function automatic bit spans_share(longint a_lo, longint a_hi, longint b_lo, longint b_hi);
    longint lo;
    longint hi;
    lo = (b_lo > a_lo) ? b_lo : a_lo;
    hi = (b_hi < a_hi) ? b_hi : a_hi;
    return hi > lo;
  endfunction

  // apply one accepted beat to the held box, or work out the hit it must give
  function automatic void apply_beat(box_beat_t b);
    half_box_t r;
    half_box_t q;
    longint    px;
    longint    py;
    logic      hit;
    if (b.kind == abct_pkg::KIND_LOAD) begin
      held_ref   = b;
      load_count = load_count + 1;
      return;
    end
    if (b.kind == abct_pkg::KIND_NONE) begin
      dropped_count = dropped_count + 1;
      return;
    end
    r  = to_half_box(held_ref);
    q  = to_half_box(b);
    px = 2 * longint'(b.pos_x);
    py = 2 * longint'(b.pos_y);
    case (b.kind)
      abct_pkg::KIND_OVERLAP: begin
        hit = spans_share(r.x, r.x + r.w, q.x, q.x + q.w) &&
              spans_share(r.y, r.y + r.h, q.y, q.y + q.h);
      end
      abct_pkg::KIND_POINT: begin
        // inclusive edge at width minus one pixel
        hit = px >= r.x && px <= r.x + r.w - 2 && py >= r.y && py <= r.y + r.h - 2;
      end
      abct_pkg::KIND_LEFT: begin
        hit = (r.x >= q.x + q.w) && (r.x + r.mx < q.x + q.w + q.mx) &&
              spans_share(r.y + r.my, r.y + r.h + r.my, q.y + q.my, q.y + q.h + q.my);
      end
      abct_pkg::KIND_RIGHT: begin
        hit = (r.x + r.w <= q.x) && (r.x + r.w + r.mx > q.x + q.mx) &&
              spans_share(r.y + r.my, r.y + r.h + r.my, q.y + q.my, q.y + q.h + q.my);
      end
      abct_pkg::KIND_TOP: begin
        hit = (r.y >= q.y + q.h) && (r.y + r.my < q.y + q.h + q.my) &&
              spans_share(r.x + r.mx, r.x + r.w + r.mx, q.x + q.mx, q.x + q.w + q.mx);
      end
      default: begin
        // bottom
        hit = (r.y + r.h <= q.y) && (r.y + r.h + r.my > q.y + q.my) &&
              spans_share(r.x + r.mx, r.x + r.w + r.mx, q.x + q.mx, q.x + q.w + q.mx);
      end
    endcase
    hits_awaited.push_back(hit);
    test_count = test_count + 1;
  endfunction

  task automatic queue_beat(logic [KW-1:0] k, int px, int py, int w, int h,
                            logic [AW-1:0] a, int mx, int my);
    box_beat_t b;
    b.kind   = k;
    b.pos_x  = CW'(px);
    b.pos_y  = CW'(py);
    b.width  = SW'(w);
    b.height = SW'(h);
    b.anchor = a;
    b.move_x = MW'(mx);
    b.move_y = MW'(my);
    beats_to_send.push_back(b);
  endtask

  // mostly boxes and points clustered round the held box with small sizes
  // and moves, so that hits and near misses are common; some beats are
  // pure noise over the whole field ranges
  task automatic queue_random_beat();
    box_beat_t b;
    int        roll;
    roll     = $urandom_range(0, 99);
    b.anchor = ($urandom_range(0, 7) == 0) ? AW'($urandom_range(9, 15))
                                           : AW'($urandom_range(0, 8));
    if (roll < 12) begin
      b.kind   = KW'($urandom);
      b.pos_x  = CW'($urandom);
      b.pos_y  = CW'($urandom);
      b.width  = SW'($urandom);
      b.height = SW'($urandom);
      b.anchor = AW'($urandom);
      b.move_x = MW'($urandom);
      b.move_y = MW'($urandom);
    end else begin
      if (roll < 24)
        b.kind = abct_pkg::KIND_LOAD;
      else if (roll < 27)
        b.kind = abct_pkg::KIND_NONE;
      else
        b.kind = KW'($urandom_range(abct_pkg::KIND_OVERLAP, abct_pkg::KIND_BOTTOM));
      b.width  = ($urandom_range(0, 19) == 0) ? SW'($urandom) : SW'($urandom_range(0, 40));
      b.height = ($urandom_range(0, 19) == 0) ? SW'($urandom) : SW'($urandom_range(0, 40));
      b.pos_x  = CW'(aim_x + int'($urandom_range(0, 120)) - 60);
      b.pos_y  = CW'(aim_y + int'($urandom_range(0, 120)) - 60);
      b.move_x = ($urandom_range(0, 9) == 0) ? MW'($urandom) : MW'(int'($urandom_range(0, 80)) - 40);
      b.move_y = ($urandom_range(0, 9) == 0) ? MW'($urandom) : MW'(int'($urandom_range(0, 80)) - 40);
      if (b.kind == abct_pkg::KIND_LOAD && $urandom_range(0, 3) == 0) begin
        // hop somewhere new, wrap-around near the coordinate limits included
        aim_x   = int'($urandom_range(0, 65535)) - 32768;
        aim_y   = int'($urandom_range(0, 65535)) - 32768;
        b.pos_x = CW'(aim_x);
        b.pos_y = CW'(aim_y);
      end
    end
    beats_to_send.push_back(b);
  endtask

  // driver: presents beats from the queue, holds each one until taken and
  // inserts random idle bursts between beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      calm = beats_to_send.size() < CALM_TAIL;
      if ($urandom_range(0, 49) == 0)
        send_idles = ~send_idles;
      // a beat taken at this edge goes to the predictor
      if (in_valid_i && !in_stall_o)
        apply_beat(on_wire);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap   = send_gap - 1;
          gap_cycles = gap_cycles + 1;
          in_valid_i <= 1'b0;
        end else if (beats_to_send.size() > 0) begin
          on_wire = beats_to_send.pop_front();
          kind_i     <= on_wire.kind;
          pos_x_i    <= on_wire.pos_x;
          pos_y_i    <= on_wire.pos_y;
          width_i    <= on_wire.width;
          height_i   <= on_wire.height;
          anchor_i   <= on_wire.anchor;
          move_x_i   <= on_wire.move_x;
          move_y_i   <= on_wire.move_y;
          in_valid_i <= 1'b1;
          // idle burst after this beat has gone
          if (!calm && send_idles && $urandom_range(0, 5) == 0)
            send_gap = $urandom_range(1, 14);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat against the oldest awaited hit and
  // stalls the result channel in random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (hits_awaited.size() == 0) begin
          $error("result beat with no test beat awaiting it: hit expected none, actual %0b",
                 hit_o);
          fault_count = fault_count + 1;
        end else begin
          hit_wanted = hits_awaited.pop_front();
          if (hit_o !== hit_wanted) begin
            $error("hit mismatch: expected %0b, actual %0b", hit_wanted, hit_o);
            fault_count = fault_count + 1;
          end
          if (hit_o === 1'b1)
            hit_count = hit_count + 1;
        end
      end
      if ($urandom_range(0, 49) == 0)
        recv_idles = ~recv_idles;
      if (stall_left > 0) begin
        stall_left   = stall_left - 1;
        stall_cycles = stall_cycles + 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm && recv_idles && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 14);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d beats unsent, %0d hits awaited",
               cycle_count, beats_to_send.size(), hits_awaited.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int counted;

    // directed part
    // nothing loaded yet: the reset box is empty and meets nothing
    queue_beat(abct_pkg::KIND_OVERLAP, 0, 0, 10, 10, abct_pkg::ANC_CENTER, 0, 0);
    queue_beat(abct_pkg::KIND_POINT, 0, 0, 0, 0, abct_pkg::ANC_CENTER, 0, 0);
    // odd sizes about a centre anchor land on half pixels
    queue_beat(abct_pkg::KIND_LOAD, 100, 100, 11, 7, abct_pkg::ANC_CENTER, 0, 0);
    queue_beat(abct_pkg::KIND_OVERLAP, 105, 100, 1, 1, abct_pkg::ANC_TOP_LEFT, 0, 0);
    queue_beat(abct_pkg::KIND_OVERLAP, 106, 100, 1, 1, abct_pkg::ANC_TOP_LEFT, 0, 0);
    queue_beat(abct_pkg::KIND_OVERLAP, 100, 100, 0, 5, abct_pkg::ANC_CENTER, 0, 0);
    queue_beat(abct_pkg::KIND_OVERLAP, 94, 96, 3, 3, abct_pkg::ANC_CENTER_TOP, 0, 0);
    queue_beat(abct_pkg::KIND_OVERLAP, 106, 104, 4, 4, abct_pkg::ANC_CENTER_BOTTOM, 0, 0);
    // point on the inclusive and exclusive edges, junk in the unused fields
    queue_beat(abct_pkg::KIND_POINT, 95, 97, 4095, 4095, 4'hf, -2048, 2047);
    queue_beat(abct_pkg::KIND_POINT, 105, 103, 0, 0, abct_pkg::ANC_CENTER, 0, 0);
    queue_beat(abct_pkg::KIND_POINT, 94, 97, 0, 0, abct_pkg::ANC_CENTER, 0, 0);
    // swept tests, each side with a box arranged to be hit
    queue_beat(abct_pkg::KIND_LOAD, 100, 100, 10, 10, abct_pkg::ANC_TOP_LEFT, -20, 0);
    queue_beat(abct_pkg::KIND_LEFT, 90, 100, 10, 10, abct_pkg::ANC_TOP_RIGHT, 0, 3);
    queue_beat(abct_pkg::KIND_LOAD, 110, 100, 10, 10, abct_pkg::ANC_TOP_RIGHT, 20, 0);
    queue_beat(abct_pkg::KIND_RIGHT, 120, 105, 10, 10, abct_pkg::ANC_CENTER_LEFT, -2, 0);
    queue_beat(abct_pkg::KIND_LOAD, 100, 110, 10, 10, abct_pkg::ANC_BOTTOM_LEFT, 0, -20);
    queue_beat(abct_pkg::KIND_TOP, 105, 85, 10, 10, abct_pkg::ANC_CENTER, 0, 0);
    queue_beat(abct_pkg::KIND_LOAD, 110, 110, 10, 10, abct_pkg::ANC_BOTTOM_RIGHT, 0, 20);
    queue_beat(abct_pkg::KIND_BOTTOM, 110, 120, 10, 10, abct_pkg::ANC_CENTER_RIGHT, 1, 0);
    // field extremes, unused anchor code taken as top-left
    queue_beat(abct_pkg::KIND_LOAD, -32768, -32768, 4095, 4095, 4'hf, -2048, -2048);
    queue_beat(abct_pkg::KIND_OVERLAP, 32767, 32767, 4095, 4095,
               abct_pkg::ANC_BOTTOM_RIGHT, 2047, 2047);
    queue_beat(abct_pkg::KIND_POINT, -32768, -32768, 0, 0, abct_pkg::ANC_CENTER, 0, 0);
    queue_beat(abct_pkg::KIND_BOTTOM, -32768, 32767, 4095, 4095, 4'h9, 2047, -2048);
    // unused kind changes nothing
    queue_beat(abct_pkg::KIND_NONE, -1, -1, 4095, 4095, 4'hf, -1, -1);
    queue_beat(abct_pkg::KIND_POINT, -28674, -28674, 0, 0, abct_pkg::ANC_CENTER, 0, 0);

    // random part
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      queue_random_beat();
      if (beats_to_send[$].kind != abct_pkg::KIND_NONE)
        counted = counted + 1;
    end

    // reset held low from the start, released at an edge
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: everything sent, every awaited hit seen, then a latency margin
    // for any stray result beat
    while (beats_to_send.size() != 0 || in_valid_i || hits_awaited.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d test beats (%0d hits), %0d loads and %0d unused-kind beats",
             test_count, hit_count, load_count, dropped_count);
    $display("with %0d sender idle and %0d receiver stall cycles in %0d cycles",
             gap_cycles, stall_cycles, cycle_count);
    if (fault_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ files.f @@
design/abct_pkg.sv
design/abct_ctrl.sv
design/abct_dp.sv
design/anchored_box_collision_test.sv
sim/tb.sv
